>>> src/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Types, constants and the symbol-to-character map shared by the encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam logic [6:0] PAD_CHAR   = 7'h3D;  // '='
    localparam logic [6:0] LOWER_BASE = 7'h61;  // 'a'
    localparam logic [6:0] UPPER_BASE = 7'h41;  // 'A'
    localparam logic [6:0] DIGIT_BASE = 7'h30;  // '0'
    localparam logic [6:0] DASH_CHAR  = 7'h2D;  // '-'
    localparam logic [6:0] UNDER_CHAR = 7'h5F;  // '_'

    localparam logic [6:0] UPPER_OFS  = 7'd26;
    localparam logic [6:0] DIGIT_OFS  = 7'd52;
    localparam logic [6:0] DASH_SYM   = 7'd62;

    // place of the next byte within its three-byte group
    typedef enum logic [1:0] {
        POS_FIRST  = 2'd0,
        POS_SECOND = 2'd1,
        POS_THIRD  = 2'd2
    } t_pos;

    // one output character: a 6-bit symbol or padding
    typedef struct packed {
        logic       pad;
        logic [5:0] six;
    } t_slot;

    // all characters caused by one input item
    typedef struct packed {
        t_slot [3:0] slots;
        logic  [1:0] last_idx;
        logic        msg_end;
    } t_run;

    function automatic logic [6:0] sym_to_ascii(input logic [5:0] six);
        logic [6:0] s;
        s = {1'b0, six};
        if (s < UPPER_OFS) begin
            return LOWER_BASE + s;
        end else if (s < DIGIT_OFS) begin
            return UPPER_BASE + (s - UPPER_OFS);
        end else if (s < DASH_SYM) begin
            return DIGIT_BASE + (s - DIGIT_OFS);
        end else if (s == DASH_SYM) begin
            return DASH_CHAR;
        end else begin
            return UNDER_CHAR;
        end
    endfunction

endpackage

>>> src/b64e_in_if.sv
// ----------------------------------------------------------------------------
// b64e_in_if
// Input channel: one raw byte and its end-of-message flag per item.
// ----------------------------------------------------------------------------
interface b64e_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

>>> src/b64e_out_if.sv
// ----------------------------------------------------------------------------
// b64e_out_if
// Output channel: one encoded ASCII character per item.
// ----------------------------------------------------------------------------
interface b64e_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       run_last;
    logic       message_end;

    modport source (output valid, output out_char, output run_last,
                    output message_end, input ready);
    modport sink   (input valid, input out_char, input run_last,
                    input message_end, output ready);
endinterface

>>> src/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Accepts bytes, tracks the group position and leftover bits, and builds
// the run of symbols and padding that each byte causes.
// ----------------------------------------------------------------------------
module b64e_front
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_in_byte,
    input  logic       i_is_last,
    output logic       o_ready,
    output logic       o_push,
    output t_run       o_run,
    input  logic       i_q_ready
);

    t_pos       r_pos;
    t_pos       n_pos;
    logic [3:0] r_left;
    logic [3:0] n_left;
    logic       accept;

    assign o_ready = i_q_ready;
    assign o_push  = i_valid;
    assign accept  = i_valid && i_q_ready;

    always_comb begin
        o_run         = '0;
        o_run.msg_end = i_is_last;
        n_pos         = POS_FIRST;
        n_left        = '0;
        case (r_pos)
            POS_SECOND: begin
                o_run.slots[0] = '{pad: 1'b0, six: {r_left[1:0], i_in_byte[7:4]}};
                if (i_is_last) begin
                    o_run.slots[1] = '{pad: 1'b0, six: {i_in_byte[3:0], 2'b00}};
                    o_run.slots[2] = '{pad: 1'b1, six: 6'd0};
                    o_run.last_idx = 2'd2;
                end else begin
                    o_run.last_idx = 2'd0;
                    n_pos          = POS_THIRD;
                    n_left         = i_in_byte[3:0];
                end
            end
            POS_THIRD: begin
                o_run.slots[0] = '{pad: 1'b0, six: {r_left, i_in_byte[7:6]}};
                o_run.slots[1] = '{pad: 1'b0, six: i_in_byte[5:0]};
                o_run.last_idx = 2'd1;
            end
            default: begin
                // first byte of a group, and the unused position code
                o_run.slots[0] = '{pad: 1'b0, six: i_in_byte[7:2]};
                if (i_is_last) begin
                    o_run.slots[1] = '{pad: 1'b0, six: {i_in_byte[1:0], 4'b0000}};
                    o_run.slots[2] = '{pad: 1'b1, six: 6'd0};
                    o_run.slots[3] = '{pad: 1'b1, six: 6'd0};
                    o_run.last_idx = 2'd3;
                end else begin
                    o_run.last_idx = 2'd0;
                    n_pos          = POS_SECOND;
                    n_left         = {2'b00, i_in_byte[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_FIRST;
            r_left <= '0;
        end else if (accept) begin
            r_pos  <= n_pos;
            r_left <= n_left;
        end
    end

endmodule

>>> src/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Two-entry queue of symbol runs between the front and the back.
// ----------------------------------------------------------------------------
module b64e_queue
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_run       i_run,
    output logic       o_ready,
    output logic       o_valid,
    output t_run       o_run,
    input  logic       i_pop,
    output logic [1:0] o_count
);

    t_run       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       wr_en;
    logic       rd_en;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_run   = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign wr_en   = i_push && o_ready;
    assign rd_en   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> src/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Holds the current run and sends its characters out one per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module b64e_back
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_run       i_q_run,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [6:0] o_out_char,
    output logic       o_run_last,
    output logic       o_message_end
);

    t_run       r_run;
    logic       r_busy;
    logic [1:0] r_idx;
    t_slot      cur;
    logic       fire;
    logic       done;

    assign cur           = r_run.slots[r_idx];
    assign o_valid       = r_busy;
    assign o_out_char    = cur.pad ? PAD_CHAR : sym_to_ascii(cur.six);
    assign o_run_last    = (r_idx == r_run.last_idx);
    assign o_message_end = o_run_last && r_run.msg_end;

    assign fire  = r_busy && i_ready;
    assign done  = fire && o_run_last;
    // take the next run when idle or as the current one finishes
    assign o_pop = i_q_valid && (!r_busy || done);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_run <= i_q_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (done) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (fire) begin
            r_idx  <= r_idx + 2'd1;
        end
    end

endmodule

>>> src/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder, one byte per input item, one character per output item.
// ----------------------------------------------------------------------------
// Each input item is a byte with an end-of-message flag; it yields one to four
// ASCII characters (alphabet a-z, A-Z, 0-9, '-', '_', padding '='), tagged with
// run_last on the last character of that byte and message_end on the final
// character of the message. The output sends one character per cycle while
// o_out.ready is high; a byte yields one character as the first or second
// byte of a group, two as the third, and three or four as the closing byte of
// a partial group. The front takes a byte every cycle while the two-entry run
// queue has room, so bytes keep arriving while earlier characters wait at the
// output.
module base64_stream_encoder
    import b64e_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    b64e_in_if.sink      i_in,
    b64e_out_if.source   o_out
);

    logic       f_push;
    t_run       f_run;
    logic       q_ready;
    logic       q_valid;
    t_run       q_run;
    logic       q_pop;
    logic [1:0] q_count;

    b64e_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_in_byte (i_in.in_byte),
        .i_is_last (i_in.is_last),
        .o_ready   (i_in.ready),
        .o_push    (f_push),
        .o_run     (f_run),
        .i_q_ready (q_ready)
    );

    b64e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_run   (f_run),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_run   (q_run),
        .i_pop   (q_pop),
        .o_count (q_count)
    );

    b64e_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_run       (q_run),
        .o_pop         (q_pop),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_out_char    (o_out.out_char),
        .o_run_last    (o_out.run_last),
        .o_message_end (o_out.message_end)
    );

    // message end only closes a run
    a_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.message_end |-> o_out.run_last)
        else $error("message_end without run_last");

    // padding is followed by padding until the run ends
    a_pad_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && (o_out.out_char == PAD_CHAR) && !o_out.run_last
        |=> o_out.valid && (o_out.out_char == PAD_CHAR))
        else $error("padding not continued to end of run");

    // queue never holds more than its two entries
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count != 2'd3)
        else $error("run queue overflow");

    // an accepted byte lands in the queue when nothing is popped in that cycle
    a_accept_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && !q_pop |=> q_count != 2'd0)
        else $error("accepted item not queued");

endmodule

>>> test/base64_stream_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_tb
// Drives bytes with end-of-message flags into the encoder and compares every
// output character against an in-bench model of its base64 variant (a-z first).
// Both sides insert random stall cycles; the sender drains the output after the
// directed bytes and while the item count is between 90 and 100, then carries on.
// ----------------------------------------------------------------------------
module base64_stream_encoder_tb;
    import b64e_pkg::*;

    // symbol index 0 sits in the top byte
    localparam logic [511:0] SYMBOL_MAP =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_";
    localparam int RANDOM_ITEMS = 150;
    localparam int MAX_GAP      = 17;
    localparam int TAIL_CYCLES  = 20;

    typedef struct packed {
        logic [6:0] ch;
        logic       run_last;
        logic       message_end;
    } t_enc_char;

    class enc_tracker;
        t_enc_char  pending_chars[$];
        t_pos       pos;
        logic [3:0] carry;
        int         fails;

        function new();
            pos   = POS_FIRST;
            carry = 4'd0;
            fails = 0;
        endfunction

        function logic [6:0] to_ascii(input logic [5:0] six);
            logic [7:0] c;
            c = SYMBOL_MAP[8 * (63 - six) +: 8];
            return c[6:0];
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction

        // predict the characters that one accepted byte produces
        function void encode_byte(input logic [7:0] b, input logic last);
            t_enc_char run[4];
            int        n;
            n = 0;
            for (int k = 0; k < 4; k++) run[k] = '0;
            case (pos)
                POS_SECOND: begin
                    run[n++].ch = to_ascii({carry[1:0], b[7:4]});
                    if (last) begin
                        run[n++].ch = to_ascii({b[3:0], 2'b00});
                        run[n++].ch = PAD_CHAR;
                        pos   = POS_FIRST;
                        carry = 4'd0;
                    end else begin
                        pos   = POS_THIRD;
                        carry = b[3:0];
                    end
                end
                POS_THIRD: begin
                    run[n++].ch = to_ascii({carry, b[7:6]});
                    run[n++].ch = to_ascii(b[5:0]);
                    pos   = POS_FIRST;
                    carry = 4'd0;
                end
                default: begin
                    run[n++].ch = to_ascii(b[7:2]);
                    if (last) begin
                        run[n++].ch = to_ascii({b[1:0], 4'b0000});
                        run[n++].ch = PAD_CHAR;
                        run[n++].ch = PAD_CHAR;
                        pos   = POS_FIRST;
                        carry = 4'd0;
                    end else begin
                        pos   = POS_SECOND;
                        carry = {2'b00, b[1:0]};
                    end
                end
            endcase
            run[n - 1].run_last    = 1'b1;
            run[n - 1].message_end = last;
            for (int k = 0; k < n; k++) pending_chars.push_back(run[k]);
        endfunction

        function void check_char(input logic [6:0] ch, input logic rl, input logic me);
            t_enc_char want;
            if (pending_chars.size() == 0) begin
                $error("unexpected character %h", ch);
                fails++;
                return;
            end
            want = pending_chars.pop_front();
            if (ch !== want.ch) begin
                $error("out_char expected %h actual %h", want.ch, ch);
                fails++;
            end
            if (rl !== want.run_last) begin
                $error("run_last expected %b actual %b", want.run_last, rl);
                fails++;
            end
            if (me !== want.message_end) begin
                $error("message_end expected %b actual %b", want.message_end, me);
                fails++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   in_idle;
    bit   out_idle;
    int   items_sent;

    enc_tracker tracker = new();

    b64e_in_if  in_if();
    b64e_out_if out_if();

    base64_stream_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // called at a falling edge; returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = in_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid   = 1'b1;
        in_if.in_byte = b;
        in_if.is_last = last;
        do @(posedge i_clk); while (!in_if.ready);
        tracker.encode_byte(b, last);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_message(input int len);
        for (int k = 0; k < len; k++) send_byte($urandom_range(0, 255), k == len - 1);
    endtask

    task automatic wait_drained();
        in_if.valid = 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
    endtask

    // output side: random stall before each character while out_idle is set
    initial begin
        int stall;
        int run_count;
        out_if.ready = 1'b0;
        out_idle     = 1'b1;
        run_count    = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (++run_count % 24 == 0) out_idle = !out_idle;
            stall = out_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                out_if.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_if.ready = 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            tracker.check_char(out_if.out_char, out_if.run_last, out_if.message_end);
            @(negedge i_clk);
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.in_byte = 8'h00;
        in_if.is_last = 1'b0;
        in_idle       = 1'b0;
        items_sent    = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // single-byte messages, padding with two '='
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // two-byte message, one '='
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        // full group closing the message
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        // symbols 62 and 63, a group completed mid-message
        send_byte(8'hFB, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b1);
        in_idle = 1'b1;
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b1);
        wait_drained();

        while (items_sent < RANDOM_ITEMS) begin
            in_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0) begin
                // loose bytes with an arbitrary end flag
                repeat ($urandom_range(1, 4)) send_byte($urandom_range(0, 255),
                                                        $urandom_range(0, 3) == 0);
            end else begin
                send_message($urandom_range(1, 10));
            end
            if (items_sent > 90 && items_sent < 100) wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (tracker.fails == 0 && tracker.pending() == 0) begin
            $display("base64_stream_encoder: match");
        end else begin
            $display("base64_stream_encoder: mismatch");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("base64_stream_encoder: mismatch");
        $finish;
    end

endmodule
